// ===== hw/rtl/elgamal_signature_engine_defines.svh =====
// Assertion macros for the signature engine checker.
`ifndef ELGAMAL_SIGNATURE_ENGINE_DEFINES_SVH
`define ELGAMAL_SIGNATURE_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define EGS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define EGS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/egs_pkg.sv =====
`timescale 1ns / 1ps

package egs_pkg;

   typedef enum logic [1:0] {
      FUNC_SIGN   = 2'd0,
      FUNC_VERIFY = 2'd1,
      FUNC_KEYGEN = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_PRIME   = 2'd0,
      REG_GEN     = 2'd1,
      REG_PRIVATE = 2'd2,
      REG_PUBLIC  = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } cmd_type;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_SN_RED  = 16'h0002,
      ST_SN_DIV  = 16'h0004,
      ST_SN_MUL  = 16'h0008,
      ST_SN_ARED = 16'h0010,
      ST_SN_DA   = 16'h0020,
      ST_SN_MRED = 16'h0040,
      ST_SN_S2   = 16'h0080,
      ST_PW_RED  = 16'h0100,
      ST_PW_LOOP = 16'h0200,
      ST_PW_SQ   = 16'h0400,
      ST_VF1     = 16'h0800,
      ST_VF2     = 16'h1000,
      ST_VF3     = 16'h2000,
      ST_KEY     = 16'h4000,
      ST_DONE    = 16'h8000
   } state_type;

endpackage

// ===== hw/rtl/elgamal_signature_engine.sv =====
`timescale 1ns / 1ps
// ElGamal signature engine: sign, verify and public key derivation.
// Each modular product or reduction runs on the one bit-serial unit; an exponentiation
// takes up to about 2*MOD_BITS such operations. Sign runs an extended Euclid and one
// exponentiation, verify three exponentiations, key one.
// One item at a time: req_stall stays high from transfer until the result is taken.
// Synchronous active-high reset restores the default modulus, generator and keys.
module elgamal_signature_engine #(
   parameter int MOD_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [MOD_BITS-1:0] csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_func,
   input  logic [MOD_BITS-1:0] req_message,
   input  logic [MOD_BITS-1:0] req_nonce,
   input  logic [MOD_BITS-1:0] req_sig_first,
   input  logic [MOD_BITS-1:0] req_sig_second,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [MOD_BITS-1:0] rsp_out_first,
   output logic [MOD_BITS-1:0] rsp_out_second,
   output logic                rsp_accept,
   output logic                rsp_status
);

   localparam int W = MOD_BITS;

   logic [W-1:0] prime_ff, gen_ff, priv_ff, pub_ff;

   egs_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic         pend_ff, pend_in;
   logic [W-1:0] msg_ff, msg_in, nonce_ff, nonce_in, s1_ff, s1_in, s2_ff, s2_in;
   logic [W-1:0] acc_ff, acc_in, base_ff, base_in, exp_ff, exp_in;
   logic [W-1:0] rem0_ff, rem0_in, rem1_ff, rem1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [W-1:0] tmp_ff, tmp_in, x_ff, x_in;
   logic [W-1:0] o1_ff, o1_in, o2_ff, o2_in;
   logic         ok_ff, ok_in, st_ff, st_in;

   egs_pkg::cmd_type cmd;
   logic [W-1:0] ua, ub, um, ures, uquot;
   logic         udone, fin;
   logic [W-1:0] n_mod;

   function automatic logic [W-1:0] sub_mod(logic [W-1:0] a, logic [W-1:0] b,
                                            logic [W-1:0] m);
      logic [W-1:0] d;
      d = a - b;
      if (a < b) begin
         d = d + m;
      end
      return d;
   endfunction

   assign n_mod = (prime_ff == '0) ? '0 : prime_ff - W'(1);
   assign fin   = pend_ff && udone;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff <= W'(3119);
         gen_ff   <= W'(7);
         priv_ff  <= W'(127);
         pub_ff   <= '0;
      end else if (csr_write) begin
         unique case (egs_pkg::reg_index_type'(csr_index))
            egs_pkg::REG_PRIME:   prime_ff <= csr_data;
            egs_pkg::REG_GEN:     gen_ff   <= csr_data;
            egs_pkg::REG_PRIVATE: priv_ff  <= csr_data;
            egs_pkg::REG_PUBLIC:  pub_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      msg_in   = msg_ff;
      nonce_in = nonce_ff;
      s1_in    = s1_ff;
      s2_in    = s2_ff;
      acc_in   = acc_ff;
      base_in  = base_ff;
      exp_in   = exp_ff;
      rem0_in  = rem0_ff;
      rem1_in  = rem1_ff;
      c0_in    = c0_ff;
      c1_in    = c1_ff;
      tmp_in   = tmp_ff;
      x_in     = x_ff;
      o1_in    = o1_ff;
      o2_in    = o2_ff;
      ok_in    = ok_ff;
      st_in    = st_ff;
      cmd.start = 1'b0;
      cmd.op    = egs_pkg::OP_MUL;
      ua = '0;
      ub = '0;
      um = prime_ff;

      unique case (state_ff)
         egs_pkg::ST_IDLE: begin
            if (req_valid) begin
               msg_in   = req_message;
               nonce_in = req_nonce;
               s1_in    = req_sig_first;
               s2_in    = req_sig_second;
               o1_in    = '0;
               o2_in    = '0;
               ok_in    = 1'b0;
               st_in    = 1'b0;
               unique case (egs_pkg::func_type'(req_func))
                  egs_pkg::FUNC_SIGN: begin
                     if (n_mod < W'(2)) begin
                        st_in    = 1'b1;
                        state_in = egs_pkg::ST_DONE;
                     end else begin
                        rem0_in  = n_mod;
                        c0_in    = '0;
                        c1_in    = W'(1);
                        state_in = egs_pkg::ST_SN_RED;
                     end
                  end
                  egs_pkg::FUNC_VERIFY: begin
                     base_in  = gen_ff;
                     exp_in   = req_message;
                     ret_in   = egs_pkg::ST_VF1;
                     state_in = egs_pkg::ST_PW_RED;
                  end
                  egs_pkg::FUNC_KEYGEN: begin
                     base_in  = gen_ff;
                     exp_in   = priv_ff;
                     ret_in   = egs_pkg::ST_KEY;
                     state_in = egs_pkg::ST_PW_RED;
                  end
                  default: state_in = egs_pkg::ST_DONE;
               endcase
            end
         end
         // Extended Euclid on (p-1, nonce mod p-1)
         egs_pkg::ST_SN_RED: begin
            cmd.op = egs_pkg::OP_DIV;
            ua = nonce_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               rem1_in  = ures;
               state_in = egs_pkg::ST_SN_DIV;
            end
         end
         egs_pkg::ST_SN_DIV: begin
            cmd.op = egs_pkg::OP_DIV;
            ua = rem0_ff;
            um = rem1_ff;
            if (rem1_ff == '0) begin
               if (rem0_ff == W'(1)) begin
                  base_in  = gen_ff;
                  exp_in   = nonce_ff;
                  ret_in   = egs_pkg::ST_SN_ARED;
                  state_in = egs_pkg::ST_PW_RED;
               end else begin
                  st_in    = 1'b1;
                  state_in = egs_pkg::ST_DONE;
               end
            end else begin
               cmd.start = !pend_ff;
               if (fin) begin
                  tmp_in   = uquot;
                  rem0_in  = rem1_ff;
                  rem1_in  = ures;
                  state_in = egs_pkg::ST_SN_MUL;
               end
            end
         end
         egs_pkg::ST_SN_MUL: begin
            ua = c1_ff;
            ub = tmp_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               c0_in    = c1_ff;
               c1_in    = sub_mod(c0_ff, ures, n_mod);
               state_in = egs_pkg::ST_SN_DIV;
            end
         end
         egs_pkg::ST_SN_ARED: begin
            cmd.op = egs_pkg::OP_DIV;
            ua = acc_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               o1_in    = acc_ff;
               tmp_in   = ures;
               state_in = egs_pkg::ST_SN_DA;
            end
         end
         egs_pkg::ST_SN_DA: begin
            ua = tmp_ff;
            ub = priv_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               x_in     = ures;
               state_in = egs_pkg::ST_SN_MRED;
            end
         end
         egs_pkg::ST_SN_MRED: begin
            cmd.op = egs_pkg::OP_DIV;
            ua = msg_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               tmp_in   = sub_mod(ures, x_ff, n_mod);
               state_in = egs_pkg::ST_SN_S2;
            end
         end
         egs_pkg::ST_SN_S2: begin
            ua = tmp_ff;
            ub = c0_ff;
            um = n_mod;
            cmd.start = !pend_ff;
            if (fin) begin
               o2_in    = ures;
               state_in = egs_pkg::ST_DONE;
            end
         end
         // Square-and-multiply, LSB first; returns to ret_ff
         egs_pkg::ST_PW_RED: begin
            cmd.op = egs_pkg::OP_DIV;
            ua = base_ff;
            if (prime_ff < W'(2)) begin
               acc_in   = '0;
               state_in = ret_ff;
            end else begin
               cmd.start = !pend_ff;
               if (fin) begin
                  base_in  = ures;
                  acc_in   = W'(1);
                  state_in = egs_pkg::ST_PW_LOOP;
               end
            end
         end
         egs_pkg::ST_PW_LOOP: begin
            ua = acc_ff;
            ub = base_ff;
            if (exp_ff == '0) begin
               state_in = ret_ff;
            end else if (!exp_ff[0]) begin
               state_in = egs_pkg::ST_PW_SQ;
            end else begin
               cmd.start = !pend_ff;
               if (fin) begin
                  acc_in   = ures;
                  state_in = egs_pkg::ST_PW_SQ;
               end
            end
         end
         egs_pkg::ST_PW_SQ: begin
            ua = base_ff;
            ub = base_ff;
            cmd.start = !pend_ff;
            if (fin) begin
               base_in  = ures;
               exp_in   = exp_ff >> 1;
               state_in = egs_pkg::ST_PW_LOOP;
            end
         end
         egs_pkg::ST_VF1: begin
            tmp_in   = acc_ff;
            base_in  = pub_ff;
            exp_in   = s1_ff;
            ret_in   = egs_pkg::ST_VF2;
            state_in = egs_pkg::ST_PW_RED;
         end
         egs_pkg::ST_VF2: begin
            x_in     = acc_ff;
            base_in  = s1_ff;
            exp_in   = s2_ff;
            ret_in   = egs_pkg::ST_VF3;
            state_in = egs_pkg::ST_PW_RED;
         end
         egs_pkg::ST_VF3: begin
            ua = x_ff;
            ub = acc_ff;
            cmd.start = !pend_ff;
            if (fin) begin
               ok_in    = (ures == tmp_ff);
               state_in = egs_pkg::ST_DONE;
            end
         end
         egs_pkg::ST_KEY: begin
            o1_in    = acc_ff;
            state_in = egs_pkg::ST_DONE;
         end
         egs_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               state_in = egs_pkg::ST_IDLE;
            end
         end
         default: state_in = egs_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (cmd.start) begin
         pend_in = 1'b1;
      end else if (udone) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= egs_pkg::ST_IDLE;
         ret_ff   <= egs_pkg::ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pend_ff  <= pend_in;
      end
      msg_ff   <= msg_in;
      nonce_ff <= nonce_in;
      s1_ff    <= s1_in;
      s2_ff    <= s2_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      exp_ff   <= exp_in;
      rem0_ff  <= rem0_in;
      rem1_ff  <= rem1_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      tmp_ff   <= tmp_in;
      x_ff     <= x_in;
      o1_ff    <= o1_in;
      o2_ff    <= o2_in;
      ok_ff    <= ok_in;
      st_ff    <= st_in;
   end

   egs_modunit #(.W(W)) u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .op_a     (ua),
      .op_b     (ub),
      .op_m     (um),
      .done     (udone),
      .result   (ures),
      .quotient (uquot)
   );

   assign req_stall      = (state_ff != egs_pkg::ST_IDLE);
   assign rsp_valid      = (state_ff == egs_pkg::ST_DONE);
   assign rsp_out_first  = o1_ff;
   assign rsp_out_second = o2_ff;
   assign rsp_accept     = ok_ff;
   assign rsp_status     = st_ff;

endmodule

// ===== hw/rtl/egs_modunit.sv =====
`timescale 1ns / 1ps

// Bit-serial modular unit.
// OP_MUL: a*b mod m (a must be below m), MSB-first double-and-add, W steps.
// OP_DIV: a / m and a mod m, restoring division, W steps.
// A modulus below 2 yields a zero result.
module egs_modunit #(
   parameter int W = 31
) (
   input  logic           clock,
   input  logic           reset,
   input  egs_pkg::cmd_type cmd,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   input  logic [W-1:0]   op_m,
   output logic           done,
   output logic [W-1:0]   result,
   output logic [W-1:0]   quotient
);

   localparam int CW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   egs_pkg::op_type op_ff, op_in;
   logic [W-1:0]    a_ff, a_in;
   logic [W-1:0]    b_ff, b_in;
   logic [W-1:0]    m_ff, m_in;
   logic [W-1:0]    r_ff, r_in;
   logic [W-1:0]    q_ff, q_in;

   logic [W:0] dbl, sum, shl;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      r_in    = r_ff;
      q_in    = q_ff;

      dbl = {r_ff, 1'b0};
      if (dbl >= {1'b0, m_ff}) begin
         dbl = dbl - {1'b0, m_ff};
      end
      sum = b_ff[W-1] ? (dbl + {1'b0, a_ff}) : dbl;
      if (sum >= {1'b0, m_ff}) begin
         sum = sum - {1'b0, m_ff};
      end

      shl = {r_ff, q_ff[W-1]};
      if (shl >= {1'b0, m_ff}) begin
         shl = shl - {1'b0, m_ff};
      end

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(W);
         op_in   = cmd.op;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = op_m;
         r_in    = '0;
         q_in    = op_a;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (op_ff == egs_pkg::OP_MUL) begin
            r_in = sum[W-1:0];
            b_in = {b_ff[W-2:0], 1'b0};
         end else begin
            r_in = shl[W-1:0];
            q_in = {q_ff[W-2:0], ({r_ff, q_ff[W-1]} >= {1'b0, m_ff})};
         end
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign result   = (m_ff < W'(2)) ? '0 : r_ff;
   assign quotient = q_ff;

endmodule

// ===== hw/rtl/egs_checker.sv =====
`timescale 1ns / 1ps
`include "elgamal_signature_engine_defines.svh"

module egs_checker #(
   parameter int MOD_BITS = 31
) (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [MOD_BITS-1:0] rsp_out_first,
   input logic [MOD_BITS-1:0] rsp_out_second,
   input logic                rsp_accept,
   input logic                rsp_status
);

   `EGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_first), "result dropped or changed while stalled")
   `EGS_ASSERT_NOW(a_busy_with_rsp, rsp_valid, req_stall, "request taken while a result waits")
   `EGS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall, "engine not busy after a transfer")
   `EGS_ASSERT_NOW(a_err_clean, rsp_valid && rsp_status, rsp_out_first == '0 && rsp_out_second == '0 && !rsp_accept, "error result carries data")
   `EGS_ASSERT_NOW(a_acc_clean, rsp_valid && rsp_accept, rsp_out_first == '0 && rsp_out_second == '0 && !rsp_status, "verify result carries data")

endmodule

bind elgamal_signature_engine egs_checker #(.MOD_BITS(MOD_BITS)) u_egs_checker (.*);
